### rtl/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int COORD_BITS_DEF  = 11;
  localparam int RADIUS_BITS_DEF = 10;

  // Depth of the queue between the front and the walk.
  localparam int QUEUE_DEPTH = 2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam logic [1:0] QUAD_PX_PY = 2'd0;
  localparam logic [1:0] QUAD_NX_PY = 2'd1;
  localparam logic [1:0] QUAD_NX_NY = 2'd2;
  localparam logic [1:0] QUAD_PX_NY = 2'd3;

endpackage

`default_nettype wire

### rtl/mer_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface mer_in_if #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  modport source (
    output valid, req_type, center_x, center_y, radius_x, radius_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, center_x, center_y, radius_x, radius_y,
    output ready
  );
endinterface

interface mer_out_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic [1:0]                   quadrant;
  logic                         last_of_step;
  logic                         finished;

  modport source (
    output valid, pixel_x, pixel_y, quadrant, last_of_step, finished,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, quadrant, last_of_step, finished,
    output ready
  );
endinterface

interface mer_word_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/mer_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_front #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mer_in_if.sink      items,
  mer_word_if.source  queue
);

  localparam int IW    = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS;
  localparam int DEPTH = mer_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [IW-1:0] slot [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;
  logic          is_step;

  assign items.ready = (count != CW'(DEPTH));
  assign queue.valid = (count != '0);
  assign queue.data  = slot[rd_ptr];

  assign push    = items.valid && items.ready;
  assign pop     = queue.valid && queue.ready;
  assign is_step = (items.req_type == mer_pkg::REQ_STEP);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {is_step, items.center_x, items.center_y,
                       items.radius_x, items.radius_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mer_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_walk #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mer_word_if.sink    queue,
  mer_word_if.source  job
);

  localparam int CB  = COORD_BITS;
  localparam int RB  = RADIUS_BITS;
  localparam int XW  = RB + 1;
  localparam int YW  = RB + 2;
  localparam int SQW = 2 * RB;
  localparam int MW  = 2 * RB + 3;
  localparam int DW  = 4 * RB + 8;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_S0   = 5'd1;
  localparam logic [4:0] ST_S1   = 5'd2;
  localparam logic [4:0] ST_S2   = 5'd3;
  localparam logic [4:0] ST_S3   = 5'd4;
  localparam logic [4:0] ST_S4   = 5'd5;
  localparam logic [4:0] ST_T2   = 5'd6;
  localparam logic [4:0] ST_T3   = 5'd7;
  localparam logic [4:0] ST_E1   = 5'd8;
  localparam logic [4:0] ST_E2   = 5'd9;
  localparam logic [4:0] ST_E3   = 5'd10;
  localparam logic [4:0] ST_E4   = 5'd11;
  localparam logic [4:0] ST_EMIT = 5'd12;
  localparam logic [4:0] ST_U1   = 5'd13;
  localparam logic [4:0] ST_U2   = 5'd14;
  localparam logic [4:0] ST_V1   = 5'd15;
  localparam logic [4:0] ST_V2   = 5'd16;

  logic [4:0]            state;
  logic [4:0]            state_next;
  logic [CB-1:0]         cx;
  logic [CB-1:0]         cy;
  logic [RB-1:0]         rx;
  logic [RB-1:0]         ry;
  logic [SQW-1:0]        rx2;
  logic [SQW-1:0]        ry2;
  logic [XW-1:0]         px;
  logic signed [YW-1:0]  py;
  logic                  reg2;
  logic signed [DW-1:0]  dec;
  logic signed [DW-1:0]  tmpa;
  logic signed [DW-1:0]  tmpb;
  logic signed [DW-1:0]  kq;
  logic signed [2*MW-1:0] prod;

  logic                  q_step;
  logic [CB-1:0]         q_cx;
  logic [CB-1:0]         q_cy;
  logic [RB-1:0]         q_rx;
  logic [RB-1:0]         q_ry;

  logic [XW-1:0]         pxi;
  logic signed [YW-1:0]  pyd;
  logic signed [MW-1:0]  rx_m;
  logic signed [MW-1:0]  ry_m;
  logic signed [MW-1:0]  rx2_m;
  logic signed [MW-1:0]  ry2_m;
  logic signed [MW-1:0]  px_m;
  logic signed [MW-1:0]  pxi_m;
  logic signed [MW-1:0]  py_m;
  logic signed [MW-1:0]  pyd_m;
  logic signed [MW-1:0]  ma;
  logic signed [MW-1:0]  mb;
  logic signed [DW-1:0]  pext;
  logic signed [DW-1:0]  pdbl;
  logic signed [DW-1:0]  rx2_w;
  logic signed [DW-1:0]  ry2_w;
  logic signed [DW-1:0]  px_w;
  logic                  py_pos;
  logic                  stay;
  logic                  fin;
  logic                  dec_neg;
  logic                  dec_pos;
  logic                  job_go;

  assign {q_step, q_cx, q_cy, q_rx, q_ry} = queue.data;

  assign pxi   = px + 1'b1;
  assign pyd   = py - 1'b1;
  assign rx_m  = {{(MW-RB){1'b0}}, rx};
  assign ry_m  = {{(MW-RB){1'b0}}, ry};
  assign rx2_m = {{(MW-SQW){1'b0}}, rx2};
  assign ry2_m = {{(MW-SQW){1'b0}}, ry2};
  assign px_m  = {{(MW-XW){1'b0}}, px};
  assign pxi_m = {{(MW-XW){1'b0}}, pxi};
  assign py_m  = {{(MW-YW){py[YW-1]}}, py};
  assign pyd_m = {{(MW-YW){pyd[YW-1]}}, pyd};

  assign pext  = {{(DW-2*MW){prod[2*MW-1]}}, prod};
  assign pdbl  = {pext[DW-2:0], 1'b0};
  assign rx2_w = {{(DW-SQW){1'b0}}, rx2};
  assign ry2_w = {{(DW-SQW){1'b0}}, ry2};
  assign px_w  = {{(DW-XW){1'b0}}, px};

  assign py_pos  = !py[YW-1] && (py != '0);
  assign stay    = py_pos && (tmpa < pext);
  assign fin     = reg2 && py[YW-1];
  assign dec_neg = dec[DW-1];
  assign dec_pos = !dec[DW-1] && (dec != '0);

  assign queue.ready = (state == ST_IDLE);
  assign job.valid   = (state == ST_EMIT);
  assign job.data    = {fin, cx, cy, px, py};
  assign job_go      = job.valid && job.ready;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_IDLE: begin ma = ry2_m; mb = px_m; end
      ST_S0:   begin ma = rx_m;  mb = rx_m; end
      ST_S1:   begin ma = ry_m;  mb = ry_m; end
      ST_S2:   begin ma = rx2_m; mb = ry_m; end
      ST_S3:   begin ma = rx2_m; mb = ry2_m; end
      ST_T2:   begin ma = rx2_m; mb = py_m; end
      ST_T3:   begin ma = px_m;  mb = px_m; end
      ST_E1:   begin ma = pyd_m; mb = pyd_m; end
      ST_E2:   begin ma = ry2_m; mb = tmpa[MW-1:0]; end
      ST_E3:   begin ma = rx2_m; mb = tmpb[MW-1:0]; end
      ST_EMIT: begin
        if (reg2) begin
          ma = rx2_m;
          mb = pyd_m;
        end else begin
          ma = ry2_m;
          mb = pxi_m;
        end
      end
      ST_U1:   begin ma = rx2_m; mb = pyd_m; end
      ST_V1:   begin ma = ry2_m; mb = pxi_m; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (queue.valid) begin
          if (!q_step) begin
            state_next = ST_S0;
          end else if (reg2) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_T2;
          end
        end
      end
      ST_S0:   state_next = ST_S1;
      ST_S1:   state_next = ST_S2;
      ST_S2:   state_next = ST_S3;
      ST_S3:   state_next = ST_S4;
      ST_S4:   state_next = ST_IDLE;
      ST_T2:   state_next = ST_T3;
      ST_T3:   state_next = stay ? ST_EMIT : ST_E1;
      ST_E1:   state_next = ST_E2;
      ST_E2:   state_next = ST_E3;
      ST_E3:   state_next = ST_E4;
      ST_E4:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (job_go) begin
          if (fin) begin
            state_next = ST_IDLE;
          end else if (reg2) begin
            state_next = ST_V1;
          end else begin
            state_next = ST_U1;
          end
        end
      end
      ST_U1:   state_next = dec_neg ? ST_IDLE : ST_U2;
      ST_U2:   state_next = ST_IDLE;
      ST_V1:   state_next = dec_pos ? ST_IDLE : ST_V2;
      ST_V2:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      ST_S3: tmpa <= pext;
      ST_T2: tmpa <= pext;
      ST_E1: tmpa <= pext + px_w;
      ST_E3: tmpa <= pext + kq;
      ST_U1: tmpa <= dec + pdbl + rx2_w;
      ST_V1: tmpa <= dec - pdbl + rx2_w;
      default: tmpa <= tmpa;
    endcase
    if (state == ST_E2) begin
      tmpb <= pext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cx    <= '0;
      cy    <= '0;
      rx    <= '0;
      ry    <= '0;
      rx2   <= '0;
      ry2   <= '0;
      kq    <= '0;
      px    <= '0;
      py    <= '1;
      reg2  <= 1'b0;
      dec   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (queue.valid && !q_step) begin
            cx   <= q_cx;
            cy   <= q_cy;
            rx   <= q_rx;
            ry   <= q_ry;
            px   <= '0;
            py   <= {2'b00, q_ry};
            reg2 <= 1'b0;
          end
        end
        ST_S1: rx2 <= prod[SQW-1:0];
        ST_S2: ry2 <= prod[SQW-1:0];
        ST_S4: begin
          kq  <= (ry2_w >>> 2) - pext;
          dec <= ry2_w - tmpa + (rx2_w >>> 2);
        end
        ST_E4: begin
          dec  <= tmpa + pext;
          reg2 <= 1'b1;
        end
        ST_EMIT: begin
          if (job_go && !fin) begin
            if (reg2) begin
              py <= pyd;
            end else begin
              px <= pxi;
            end
          end
        end
        ST_U1: begin
          if (dec_neg) begin
            dec <= dec + pdbl + ry2_w;
          end else begin
            py <= pyd;
          end
        end
        ST_U2: dec <= tmpa - pdbl;
        ST_V1: begin
          if (dec_pos) begin
            dec <= dec - pdbl + rx2_w;
          end else begin
            px <= pxi;
          end
        end
        ST_V2: dec <= tmpa + pdbl;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/mer_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_emit #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mer_word_if.sink    job,
  mer_out_if.source   results
);

  localparam int CB   = COORD_BITS;
  localparam int RB   = RADIUS_BITS;
  localparam int XW   = RB + 1;
  localparam int YW   = RB + 2;
  localparam int PIXW = CB + 2;
  localparam int SW   = ((CB > RB) ? CB : RB) + 3;

  logic                 j_fin;
  logic [CB-1:0]        j_cx;
  logic [CB-1:0]        j_cy;
  logic [XW-1:0]        j_px;
  logic signed [YW-1:0] j_py;

  logic                 busy;
  logic [1:0]           quad;
  logic                 h_fin;
  logic [CB-1:0]        h_cx;
  logic [CB-1:0]        h_cy;
  logic [XW-1:0]        h_px;
  logic signed [YW-1:0] h_py;

  logic [SW-1:0]        cx_s;
  logic [SW-1:0]        cy_s;
  logic [SW-1:0]        px_s;
  logic [SW-1:0]        py_s;
  logic [SW-1:0]        sum_x;
  logic [SW-1:0]        sum_y;
  logic                 plus_x;
  logic                 plus_y;
  logic                 out_go;
  logic                 out_last;

  assign {j_fin, j_cx, j_cy, j_px, j_py} = job.data;

  assign cx_s = {{(SW-CB){1'b0}}, h_cx};
  assign cy_s = {{(SW-CB){1'b0}}, h_cy};
  assign px_s = {{(SW-XW){1'b0}}, h_px};
  assign py_s = {{(SW-YW){h_py[YW-1]}}, h_py};

  assign plus_x = (quad == mer_pkg::QUAD_PX_PY) || (quad == mer_pkg::QUAD_PX_NY);
  assign plus_y = (quad == mer_pkg::QUAD_PX_PY) || (quad == mer_pkg::QUAD_NX_PY);
  assign sum_x  = plus_x ? cx_s + px_s : cx_s - px_s;
  assign sum_y  = plus_y ? cy_s + py_s : cy_s - py_s;

  assign results.valid        = busy;
  assign results.pixel_x      = h_fin ? '0 : sum_x[PIXW-1:0];
  assign results.pixel_y      = h_fin ? '0 : sum_y[PIXW-1:0];
  assign results.quadrant     = h_fin ? mer_pkg::QUAD_PX_PY : quad;
  assign results.last_of_step = out_last;
  assign results.finished     = h_fin;

  assign out_last  = h_fin || (quad == mer_pkg::QUAD_PX_NY);
  assign out_go    = results.valid && results.ready;
  assign job.ready = !busy || (out_go && out_last);

  always_ff @(posedge clk) begin
    if (job.valid && job.ready) begin
      h_fin <= j_fin;
      h_cx  <= j_cx;
      h_cy  <= j_cy;
      h_px  <= j_px;
      h_py  <= j_py;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      quad <= mer_pkg::QUAD_PX_PY;
    end else begin
      if (job.valid && job.ready) begin
        busy <= 1'b1;
        quad <= mer_pkg::QUAD_PX_PY;
      end else if (out_go) begin
        if (out_last) begin
          busy <= 1'b0;
        end else begin
          quad <= quad + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/midpoint_ellipse_rasterizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Midpoint ellipse rasterizer.
// Input words on items: a start word (req_type 0) latches the center and the
// two semi-axes; a step word (req_type 1) walks the outline by one point.
// Each step gives four pixel words on results in quadrant order, the last
// one marked with last_of_step. A step after the outline is complete gives
// a single word with finished and last_of_step set and zero pixel fields.
// Words are accepted when valid and ready are both high on a channel.
// A two-word queue sits behind the input, and the walk hands each point to
// an output stage that holds it while the receiver stalls.
// The shared multiplier of the walk sets the rate. A start squares the two
// semi-axes and sets up the decision terms; a step in region one tests
// whether the point stays there before it is emitted, and the step that
// enters region two first sets up the region-two decision term. The output
// stage gives the four pixel words of a step in turn and can take the next
// point as its last word is taken, so the walk works on a step while the
// pixels of the one before drain. Reset clears the queue and the output
// stage and returns the walk to a point past the end of the outline, so a
// step before any start reports finished.
module midpoint_ellipse_rasterizer_core #(
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mer_in_if.sink     items,
  mer_out_if.source  results
);

  localparam int QW = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS;
  localparam int JW = 1 + 2 * COORD_BITS + (RADIUS_BITS + 1) + (RADIUS_BITS + 2);

  mer_word_if #(.W(QW)) queue_link ();
  mer_word_if #(.W(JW)) job_link ();

  mer_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .queue (queue_link)
  );

  mer_walk #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_walk (
    .clk   (clk),
    .rst   (rst),
    .queue (queue_link),
    .job   (job_link)
  );

  mer_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .job     (job_link),
    .results (results)
  );

endmodule

`default_nettype wire
